// File: rtl/sof_pkg.sv
package sof_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF = 64;
  localparam logic [7:0]  SOF_BYTE        = 8'h7E;
  localparam logic [7:0]  ERR_LIMIT_RST   = 8'd3;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_LEN  = 3'd1,
    ST_OVERFLOW = 3'd2,
    ST_HDR_CSUM = 3'd3,
    ST_DAT_CSUM = 3'd4
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] frm_id;
    logic [15:0] msg_kind;
    logic [6:0]  pay_len;
    logic [7:0]  hdr_csum;
    logic [7:0]  pay_csum;
    logic [7:0]  payload_byte;
    logic [5:0]  byte_index;
    logic        last;
    logic [31:0] frames_parsed;
    logic [31:0] parse_errors;
    logic [7:0]  error_run;
  } result_t;

endpackage

// File: rtl/sof_ram.sv
module sof_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/sof_length_frame_parser.sv
// Timing: an error or empty-frame result is registered on the edge that accepts the
//   closing word and shows in the next cycle; a payload run passes S_RD_ISSUE then S_RD_LOAD.
// Throughput: one header or payload word per cycle while in_stall is low; readout of an N-word
//   payload does one RAM read issue plus one output load per word, input stalled meanwhile.
// Reset: rst_n synchronous, active low; clears parser, counters, output valid and sets
//   error_limit to 3. The payload RAM is not cleared.
module sof_length_frame_parser
  import sof_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input word channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [15:0] out_frm_id,
  output logic [15:0] out_msg_kind,
  output logic [6:0]  out_pay_len,
  output logic [7:0]  out_hdr_csum,
  output logic [7:0]  out_pay_csum,
  output logic [7:0]  out_payload_byte,
  output logic [5:0]  out_byte_index,
  output logic        out_last,
  output logic [31:0] out_frames_parsed,
  output logic [31:0] out_parse_errors,
  output logic [7:0]  out_error_run,
  // error_limit write port
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  typedef enum logic [3:0] {
    S_HUNT, S_ID_L, S_ID_H, S_LEN_L, S_LEN_H, S_TYPE_L, S_TYPE_H,
    S_HCSUM, S_DATA, S_DCSUM, S_RD_ISSUE, S_RD_LOAD
  } state_t;

  state_t      state_r;
  logic [15:0] id_r;
  logic [15:0] type_r;
  logic [7:0]  len_lo_r;   // low length byte until the high byte arrives
  logic [6:0]  len_r;      // low seven length bits; can exceed MAX_PAYLOAD after a failed check
  logic [7:0]  hsum_r;
  logic [7:0]  hcsum_r;
  logic [7:0]  psum_r;
  logic [7:0]  dcsum_r;
  logic [6:0]  cnt_r;      // payload words written so far
  logic [6:0]  rd_idx_r;   // readout position
  logic [31:0] good_r;
  logic [31:0] bad_r;
  logic [7:0]  streak_r;
  logic [7:0]  error_limit_r;
  logic        out_valid_r;
  result_t     out_r;

  logic        in_acc;
  logic        out_free;
  logic        readout;
  logic [7:0]  hsum_add;
  logic [15:0] len_full;
  logic        len_big;
  logic [6:0]  cnt_inc;
  logic        err_fire;
  status_t     err_code;
  logic [31:0] good_inc;
  logic [31:0] bad_inc;
  logic [7:0]  streak_inc;
  logic [7:0]  streak_err;
  logic        ram_we;
  logic        ram_re;
  logic [7:0]  ram_rdata;
  logic        rd_last;

  assign readout  = (state_r == S_RD_ISSUE) || (state_r == S_RD_LOAD);
  assign out_free = !out_valid_r || !out_stall;
  // hold input during payload readout, or while a result waits to be taken
  assign in_stall = readout || (out_valid_r && out_stall);
  assign in_acc   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign hsum_add = hsum_r + in_rx_byte;
  assign len_full = {in_rx_byte, len_lo_r};
  assign len_big  = len_full > 16'(MAX_PAYLOAD);
  assign cnt_inc  = cnt_r + 7'd1;
  assign rd_last  = (rd_idx_r + 7'd1) >= len_r;

  // saturating counters
  assign good_inc   = (good_r == '1) ? good_r : good_r + 32'd1;
  assign bad_inc    = (bad_r == '1) ? bad_r : bad_r + 32'd1;
  assign streak_inc = (streak_r == '1) ? streak_r : streak_r + 8'd1;
  // run clears once it reaches the limit
  assign streak_err = (streak_inc >= error_limit_r) ? 8'd0 : streak_inc;

  always_comb begin
    err_fire = 1'b0;
    err_code = ST_OK;
    if (in_acc) begin
      unique case (state_r)
        S_LEN_H: begin
          err_fire = len_big;
          err_code = ST_BAD_LEN;
        end
        S_HCSUM: begin
          err_fire = in_rx_byte != hsum_r;
          err_code = ST_HDR_CSUM;
        end
        S_DCSUM: begin
          err_fire = in_rx_byte != psum_r;
          err_code = ST_DAT_CSUM;
        end
        default: begin
          err_fire = 1'b0;
          err_code = ST_OK;
        end
      endcase
    end
  end

  assign ram_we = in_acc && (state_r == S_DATA);
  assign ram_re = state_r == S_RD_ISSUE;

  sof_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PAYLOAD)
  ) u_payload_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (in_rx_byte),
    .re    (ram_re),
    .raddr (rd_idx_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_HUNT;
      id_r          <= '0;
      type_r        <= '0;
      len_lo_r      <= '0;
      len_r         <= '0;
      hsum_r        <= '0;
      hcsum_r       <= '0;
      psum_r        <= '0;
      dcsum_r       <= '0;
      cnt_r         <= '0;
      rd_idx_r      <= '0;
      good_r        <= '0;
      bad_r         <= '0;
      streak_r      <= '0;
      error_limit_r <= ERR_LIMIT_RST;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        error_limit_r <= cfg_data;
      end
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (in_acc) begin
        unique case (state_r)
          S_HUNT: begin
            if (in_rx_byte == SOF_BYTE) begin
              id_r     <= '0;
              type_r   <= '0;
              len_lo_r <= '0;
              len_r    <= '0;
              hsum_r   <= in_rx_byte;
              psum_r   <= '0;
              cnt_r    <= '0;
              state_r  <= S_ID_L;
            end
          end
          S_ID_L: begin
            id_r[7:0] <= in_rx_byte;
            hsum_r    <= hsum_add;
            state_r   <= S_ID_H;
          end
          S_ID_H: begin
            id_r[15:8] <= in_rx_byte;
            hsum_r     <= hsum_add;
            state_r    <= S_LEN_L;
          end
          S_LEN_L: begin
            len_lo_r <= in_rx_byte;
            hsum_r   <= hsum_add;
            state_r  <= S_LEN_H;
          end
          S_LEN_H: begin
            hsum_r  <= hsum_add;
            len_r   <= len_full[6:0];
            state_r <= S_TYPE_L;
          end
          S_TYPE_L: begin
            type_r[7:0] <= in_rx_byte;
            hsum_r      <= hsum_add;
            state_r     <= S_TYPE_H;
          end
          S_TYPE_H: begin
            type_r[15:8] <= in_rx_byte;
            hsum_r       <= hsum_add;
            state_r      <= S_HCSUM;
          end
          S_HCSUM: begin
            hcsum_r <= in_rx_byte;
            state_r <= (len_r == 7'd0) ? S_DCSUM : S_DATA;
          end
          S_DATA: begin
            psum_r <= psum_r + in_rx_byte;
            cnt_r  <= cnt_inc;
            if (cnt_inc >= len_r) begin
              state_r <= S_DCSUM;
            end
          end
          S_DCSUM: begin
            // good frame only; a bad data sum is handled below
            if (!err_fire) begin
              good_r   <= good_inc;
              streak_r <= '0;
              dcsum_r  <= in_rx_byte;
              rd_idx_r <= '0;
              if (len_r == 7'd0) begin
                // empty frame: single result, no readout
                out_valid_r         <= 1'b1;
                out_r.status        <= ST_OK;
                out_r.frm_id        <= id_r;
                out_r.msg_kind      <= type_r;
                out_r.pay_len       <= len_r;
                out_r.hdr_csum      <= hcsum_r;
                out_r.pay_csum      <= in_rx_byte;
                out_r.payload_byte  <= '0;
                out_r.byte_index    <= '0;
                out_r.last          <= 1'b1;
                out_r.frames_parsed <= good_inc;
                out_r.parse_errors  <= bad_r;
                out_r.error_run     <= '0;
                state_r             <= S_HUNT;
              end else begin
                state_r <= S_RD_ISSUE;
              end
            end
          end
          default: begin
            state_r <= S_HUNT;
          end
        endcase
      end

      // payload readout: issue RAM read, then load the word when output is free
      if (state_r == S_RD_ISSUE) begin
        state_r <= S_RD_LOAD;
      end
      if ((state_r == S_RD_LOAD) && out_free) begin
        out_valid_r         <= 1'b1;
        out_r.status        <= ST_OK;
        out_r.frm_id        <= id_r;
        out_r.msg_kind      <= type_r;
        out_r.pay_len       <= len_r;
        out_r.hdr_csum      <= hcsum_r;
        out_r.pay_csum      <= dcsum_r;
        out_r.payload_byte  <= ram_rdata;
        out_r.byte_index    <= rd_idx_r[5:0];
        out_r.last          <= rd_last;
        out_r.frames_parsed <= good_r;
        out_r.parse_errors  <= bad_r;
        out_r.error_run     <= streak_r;
        rd_idx_r            <= rd_idx_r + 7'd1;
        state_r             <= rd_last ? S_HUNT : S_RD_ISSUE;
      end

      // any error: one result, back to hunting
      if (err_fire) begin
        bad_r                 <= bad_inc;
        streak_r              <= streak_err;
        out_valid_r           <= 1'b1;
        out_r                 <= '0;
        out_r.status          <= err_code;
        out_r.last            <= 1'b1;
        out_r.frames_parsed   <= good_r;
        out_r.parse_errors    <= bad_inc;
        out_r.error_run       <= streak_err;
        state_r               <= S_HUNT;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_r.status;
  assign out_frm_id        = out_r.frm_id;
  assign out_msg_kind      = out_r.msg_kind;
  assign out_pay_len       = out_r.pay_len;
  assign out_hdr_csum      = out_r.hdr_csum;
  assign out_pay_csum      = out_r.pay_csum;
  assign out_payload_byte  = out_r.payload_byte;
  assign out_byte_index    = out_r.byte_index;
  assign out_last          = out_r.last;
  assign out_frames_parsed = out_r.frames_parsed;
  assign out_parse_errors  = out_r.parse_errors;
  assign out_error_run     = out_r.error_run;

`ifndef SYNTHESIS
  // readout never runs past the stored payload
  a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD_LOAD) |-> (rd_idx_r < len_r))
    else $error("readout index beyond frame length");

  // no word is taken while the buffer is being read out
  a_no_accept_readout: assert property (@(posedge clk) disable iff (!rst_n)
    readout |-> in_stall)
    else $error("input accepted during readout");

  // an error result always closes its run
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.status != ST_OK)) |-> out_r.last)
    else $error("error result without last");

  // a readout load only happens into a free output register
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD_LOAD && out_valid_r && out_stall) |=> (state_r == S_RD_LOAD))
    else $error("readout advanced while output stalled");
`endif

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import sof_pkg::*;

  localparam int QUIET_LIMIT  = 3000;  // cycles with no handshake before giving up
  localparam int HOLD_CYCLES  = 400;   // long receiver hold-off, fills the block
  localparam int DRAIN_CYCLES = 10;    // settle time after the last expected result
  localparam int PHASE_WORDS  = 70;    // counted words per random phase

  // local copy of the parser phases
  typedef enum logic [3:0] {
    PH_HUNT, PH_ID_LO, PH_ID_HI, PH_LEN_LO, PH_LEN_HI,
    PH_TYPE_LO, PH_TYPE_HI, PH_HDR_SUM, PH_PAYLOAD, PH_DATA_SUM
  } parse_phase_t;

  typedef enum logic [1:0] {FR_GOOD, FR_BAD_LEN, FR_BAD_HDR, FR_BAD_DATA} frame_kind_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [15:0] out_frm_id;
  logic [15:0] out_msg_kind;
  logic [6:0]  out_pay_len;
  logic [7:0]  out_hdr_csum;
  logic [7:0]  out_pay_csum;
  logic [7:0]  out_payload_byte;
  logic [5:0]  out_byte_index;
  logic        out_last;
  logic [31:0] out_frames_parsed;
  logic [31:0] out_parse_errors;
  logic [7:0]  out_error_run;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = 8'h00;

  always #6 clk = ~clk;

  sof_length_frame_parser u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_frm_id        (out_frm_id),
    .out_msg_kind      (out_msg_kind),
    .out_pay_len       (out_pay_len),
    .out_hdr_csum      (out_hdr_csum),
    .out_pay_csum      (out_pay_csum),
    .out_payload_byte  (out_payload_byte),
    .out_byte_index    (out_byte_index),
    .out_last          (out_last),
    .out_frames_parsed (out_frames_parsed),
    .out_parse_errors  (out_parse_errors),
    .out_error_run     (out_error_run),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data)
  );

  // stimulus and scoreboard storage
  logic [7:0] tx_bytes[$];          // words waiting for the driver
  result_t    expected_results[$];  // predicted results, oldest first
  int         tx_counted = 0;       // words queued that the parser acts on
  int         mismatch_count = 0;
  int         tx_idle_pct = 0;      // sender gap chance, percent
  int         rx_idle_pct = 0;      // receiver stall chance, percent
  logic       hold_arm = 1'b0;

  // ---------------------------------------------------------------------------
  // Parser model: mirrors the block's state, pushes results on frame ends/errors
  // ---------------------------------------------------------------------------
  parse_phase_t m_phase;
  logic [15:0]  m_id, m_len, m_type;
  logic [7:0]   m_hsum, m_hcsum, m_psum;
  logic [6:0]   m_count;
  logic [7:0]   m_store[64];
  logic [31:0]  m_frames, m_errors;
  logic [7:0]   m_streak;
  logic [7:0]   m_limit;

  function automatic void restart_parse();
    m_phase = PH_HUNT;
    m_id    = '0;
    m_len   = '0;
    m_type  = '0;
    m_hsum  = '0;
    m_hcsum = '0;
    m_psum  = '0;
    m_count = '0;
  endfunction

  // error word: header fields zero, last set, counters updated
  function automatic void log_error(status_t code);
    result_t r;
    restart_parse();
    if (m_errors != '1) m_errors++;
    if (m_streak != 8'hFF) m_streak++;
    if (m_streak >= m_limit) m_streak = '0;  // auto-reset at the limit
    r = '0;
    r.status        = code;
    r.last          = 1'b1;
    r.frames_parsed = m_frames;
    r.parse_errors  = m_errors;
    r.error_run     = m_streak;
    expected_results.push_back(r);
  endfunction

  // good frame: one word per payload byte, or a single word if empty
  function automatic void log_frame(logic [7:0] dcsum);
    result_t r;
    int n, count;
    n = int'(m_len);
    count = (n == 0) ? 1 : n;
    if (m_frames != '1) m_frames++;
    m_streak = '0;
    for (int k = 0; k < count; k++) begin
      r = '0;
      r.status        = ST_OK;
      r.frm_id        = m_id;
      r.msg_kind      = m_type;
      r.pay_len       = 7'(n);
      r.hdr_csum      = m_hcsum;
      r.pay_csum      = dcsum;
      r.payload_byte  = (n == 0) ? 8'h00 : m_store[k];
      r.byte_index    = 6'(k);
      r.last          = (k + 1 == count);
      r.frames_parsed = m_frames;
      r.parse_errors  = m_errors;
      r.error_run     = m_streak;
      expected_results.push_back(r);
    end
    restart_parse();
  endfunction

  function automatic void parse_rx_byte(logic [7:0] b);
    case (m_phase)
      PH_HUNT: begin
        // anything but the start byte is dropped silently
        if (b == SOF_BYTE) begin
          restart_parse();
          m_hsum  = b;
          m_phase = PH_ID_LO;
        end
      end
      PH_ID_LO: begin
        m_id[7:0] = b;
        m_hsum += b;
        m_phase = PH_ID_HI;
      end
      PH_ID_HI: begin
        m_id[15:8] = b;
        m_hsum += b;
        m_phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        m_len[7:0] = b;
        m_hsum += b;
        m_phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        m_len[15:8] = b;
        m_hsum += b;
        // oversize length is flagged as soon as the high byte lands
        if (m_len > MAX_PAYLOAD_DEF) log_error(ST_BAD_LEN);
        else m_phase = PH_TYPE_LO;
      end
      PH_TYPE_LO: begin
        m_type[7:0] = b;
        m_hsum += b;
        m_phase = PH_TYPE_HI;
      end
      PH_TYPE_HI: begin
        m_type[15:8] = b;
        m_hsum += b;
        m_phase = PH_HDR_SUM;
      end
      PH_HDR_SUM: begin
        if (b != m_hsum) begin
          log_error(ST_HDR_CSUM);
        end else begin
          m_hcsum = b;
          m_phase = (m_len == 0) ? PH_DATA_SUM : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        m_store[m_count[5:0]] = b;
        m_psum += b;
        m_count++;
        if (m_count >= m_len) m_phase = PH_DATA_SUM;
      end
      PH_DATA_SUM: begin
        // empty frame expects a zero data checksum
        if (b != m_psum) log_error(ST_DAT_CSUM);
        else log_frame(b);
      end
      default: restart_parse();
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  function automatic void push_word(logic [7:0] b);
    tx_bytes.push_back(b);
    tx_counted++;
  endfunction

  // builds one frame; the broken kinds stop right after the faulty byte
  function automatic void queue_frame(logic [15:0] id, logic [15:0] len,
                                      logic [15:0] typ, frame_kind_t kind);
    logic [7:0] hdr[7];
    logic [7:0] hsum, dsum, b;
    hdr = '{SOF_BYTE, id[7:0], id[15:8], len[7:0], len[15:8], typ[7:0], typ[15:8]};
    hsum = '0;
    dsum = '0;
    for (int i = 0; i < 7; i++) begin
      push_word(hdr[i]);
      hsum += hdr[i];
      if (i == 4 && kind == FR_BAD_LEN) return;
    end
    if (kind == FR_BAD_HDR) begin
      push_word(hsum ^ 8'($urandom_range(255, 1)));
      return;
    end
    push_word(hsum);
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      push_word(b);
      dsum += b;
    end
    if (kind == FR_BAD_DATA) push_word(dsum ^ 8'($urandom_range(255, 1)));
    else push_word(dsum);
  endfunction

  // mostly short payloads, a few long and full-size ones
  function automatic logic [15:0] pick_good_len();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 16'(MAX_PAYLOAD_DEF);
    if (r < 20) return 16'($urandom_range(63, 9));
    return 16'($urandom_range(8, 0));
  endfunction

  function automatic logic [15:0] pick_bad_len();
    case ($urandom_range(3))
      0: return 16'(MAX_PAYLOAD_DEF + 1);
      1: return 16'($urandom_range(255, MAX_PAYLOAD_DEF + 1));
      2: return 16'hFFFF;
      default: return {8'($urandom_range(255, 1)), 8'($urandom)};
    endcase
  endfunction

  // well-formed frames with random content, plus noise and broken frames
  task automatic queue_random_traffic(int word_target);
    int start_n, pick;
    start_n = tx_counted;
    while (tx_counted - start_n < word_target) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        // line noise while hunting; ignored unless it hits a start byte
        repeat ($urandom_range(4, 1)) tx_bytes.push_back(8'($urandom));
      end else if (pick < 14) begin
        queue_frame(16'($urandom), pick_bad_len(), 16'($urandom), FR_BAD_LEN);
      end else if (pick < 22) begin
        queue_frame(16'($urandom), pick_good_len(), 16'($urandom), FR_BAD_HDR);
      end else if (pick < 30) begin
        queue_frame(16'($urandom), pick_good_len(), 16'($urandom), FR_BAD_DATA);
      end else begin
        queue_frame(16'($urandom), pick_good_len(), 16'($urandom), FR_GOOD);
      end
    end
  endtask

  // block idle: nothing queued, nothing offered, nothing outstanding
  task automatic wait_idle();
    while (tx_bytes.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_error_limit(logic [7:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    m_limit = value;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: holds each word until accepted, random gaps between words
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) parse_rx_byte(in_rx_byte);
      if (!in_valid || !in_stall) begin
        if (tx_bytes.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_valid   <= 1'b1;
          in_rx_byte <= tx_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long hold-off, counted on its own so the sender keeps pushing meanwhile
  int   hold_left = 0;
  logic hold_done = 1'b0;
  always @(posedge clk) begin
    if (hold_arm && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= (hold_left != 0) || ($urandom_range(99) < rx_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every accepted word against the oldest prediction
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual status %0d index %0d",
                 $time, out_status, out_byte_index);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("status", 32'(want.status), 32'(out_status));
        check_field("frm_id", 32'(want.frm_id), 32'(out_frm_id));
        check_field("msg_kind", 32'(want.msg_kind), 32'(out_msg_kind));
        check_field("pay_len", 32'(want.pay_len), 32'(out_pay_len));
        check_field("hdr_csum", 32'(want.hdr_csum), 32'(out_hdr_csum));
        check_field("pay_csum", 32'(want.pay_csum), 32'(out_pay_csum));
        check_field("payload_byte", 32'(want.payload_byte), 32'(out_payload_byte));
        check_field("byte_index", 32'(want.byte_index), 32'(out_byte_index));
        check_field("last", 32'(want.last), 32'(out_last));
        check_field("frames_parsed", want.frames_parsed, out_frames_parsed);
        check_field("parse_errors", want.parse_errors, out_parse_errors);
        check_field("error_run", 32'(want.error_run), 32'(out_error_run));
      end
    end
  end

  // watchdog: any handshake on any channel counts as progress
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[sof_length_frame_parser] ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    restart_parse();
    m_frames = '0;
    m_errors = '0;
    m_streak = '0;
    m_limit  = ERR_LIMIT_RST;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed frames at the reset limit of 3
    tx_bytes.push_back(8'h00);  // noise while hunting
    tx_bytes.push_back(8'hFF);
    tx_bytes.push_back(8'h7D);
    queue_frame(16'h0000, 16'd0, 16'hFFFF, FR_GOOD);      // empty payload
    queue_frame(16'hFFFF, 16'd1, 16'h0000, FR_GOOD);
    queue_frame(16'h1234, 16'(MAX_PAYLOAD_DEF), 16'hA55A, FR_GOOD);
    queue_frame(16'h0001, 16'(MAX_PAYLOAD_DEF + 1), 16'h0000, FR_BAD_LEN);
    queue_frame(16'h0002, 16'hFFFF, 16'h0000, FR_BAD_LEN);
    queue_frame(16'h0003, 16'h0100, 16'h0000, FR_BAD_LEN);  // high byte only
    // the third error above reached the limit and cleared the run count; a new run starts here
    queue_frame(16'h0004, 16'd3, 16'h0001, FR_BAD_HDR);
    queue_frame(16'h0005, 16'd2, 16'h0002, FR_BAD_DATA);
    queue_frame(16'h0006, 16'd0, 16'h0003, FR_BAD_DATA);  // empty, nonzero data sum
    queue_frame(16'h7E7E, 16'd2, 16'h7E7E, FR_GOOD);      // start bytes inside a frame
    wait_idle();

    // sender rarely idles, receiver mostly stalls; limit of 1
    write_error_limit(8'd1);
    tx_idle_pct = 12;
    rx_idle_pct = 84;
    queue_random_traffic(PHASE_WORDS);
    wait_idle();

    // swapped idling; limit at its maximum
    write_error_limit(8'd255);
    tx_idle_pct = 84;
    rx_idle_pct = 12;
    queue_random_traffic(PHASE_WORDS);
    wait_idle();

    // no idling, random limit; opens with a long hold-off on a full frame
    write_error_limit(8'($urandom_range(254, 2)));
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    queue_frame(16'($urandom), 16'(MAX_PAYLOAD_DEF), 16'($urandom), FR_GOOD);
    queue_random_traffic(PHASE_WORDS);
    hold_arm = 1'b1;
    wait_idle();

    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[sof_length_frame_parser] OK");
    end else begin
      $display("[sof_length_frame_parser] ERROR");
    end
    $finish;
  end

endmodule
